### design/avmm_pkg.sv
// Shared types, constants and helper functions for the averaging voltmeter.
package avmm_pkg;

    localparam int SAMPLES_PER_AVERAGE_DEF = 8;
    localparam int QUEUE_DEPTH             = 4;

    // Scaling of a raw reading: (s*33+511)/1023 by reciprocal multiply.
    localparam int SCALE_MUL   = 33;
    localparam int SCALE_RND   = 511;
    localparam int SCALE_DIV   = 1023;
    localparam int SCALE_SHIFT = 26;
    localparam int SCALE_RECIP = (2**SCALE_SHIFT + SCALE_DIV - 1) / SCALE_DIV;

    localparam int LEVEL_W = 6;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_RX     = 2'd2;

    localparam logic [7:0] ASCII_UPPER_M = 8'h4D;
    localparam logic [7:0] ASCII_LOWER_M = 8'h6D;
    localparam logic [7:0] ASCII_V       = 8'h56;
    localparam logic [7:0] ASCII_A       = 8'h61;
    localparam logic [7:0] ASCII_X       = 8'h78;
    localparam logic [7:0] ASCII_I       = 8'h69;
    localparam logic [7:0] ASCII_N       = 8'h6E;
    localparam logic [7:0] ASCII_EQ      = 8'h3D;
    localparam logic [7:0] ASCII_DOT     = 8'h2E;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NL      = 8'h0A;

    localparam logic [3:0] REP_LAST_IDX = 4'd9;

    localparam logic KIND_DISPLAY = 1'b0;
    localparam logic KIND_SERIAL  = 1'b1;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] sample;
        logic [7:0] rx_char;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [6:0] segments;
        logic       digit_select;
        logic [7:0] tx_byte;
        logic       last;
    } t_out_item;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_TICK   = 2'd1,
        CMD_MAX    = 2'd2,
        CMD_MIN    = 2'd3
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code            code;
        logic [LEVEL_W-1:0]   scaled;
    } t_cmd_req;

    function automatic logic [6:0] seg_code(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'h0: s = 7'h3F;
            4'h1: s = 7'h06;
            4'h2: s = 7'h5B;
            4'h3: s = 7'h4F;
            4'h4: s = 7'h66;
            4'h5: s = 7'h6D;
            4'h6: s = 7'h7D;
            4'h7: s = 7'h07;
            4'h8: s = 7'h7F;
            4'h9: s = 7'h6F;
            4'hA: s = 7'h77;
            4'hB: s = 7'h7C;
            4'hC: s = 7'h39;
            4'hD: s = 7'h5E;
            4'hE: s = 7'h79;
            default: s = 7'h71;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] dec_tens(input logic [LEVEL_W-1:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    function automatic logic [3:0] dec_units(input logic [LEVEL_W-1:0] v);
        logic [3:0] t;
        logic [5:0] u;
        t = dec_tens(v);
        u = v - 6'(t) * 6'd10;
        return u[3:0];
    endfunction

endpackage

### design/averaging_voltmeter_min_max_display.sv
// Top level of the averaging voltmeter with min/max display and report.
//
// Input queue side: an item is taken when push is high and full is low.
// Opcode 0 carries a converter sample, 1 a display refresh tick, 2 a
// received character ('M' or 'm' request a max or min report).
// Result queue side: the oldest result shows while empty is low and is
// taken when pop is high. A tick gives one display result; a report gives
// ten serial bytes "VMax=d.dV\n" or "VMin=d.dV\n", last set on the final one.
// Samples and other characters give no result.
// Throughput: one item per cycle while full is low; the front end scales
// each sample with one reciprocal multiply and drops it in a four-entry
// command queue. A new average passes from the queue through the sum and
// pending registers into level, max and min; a tick or report right behind
// it waits while the average is pending. A tick result passes from the queue
// into the output register; a report sends one byte per cycle from its
// report state while the output is free, and while it runs a later tick or
// report holds the queue head and everything behind it waits.
// A stalled receiver holds the output register; the queue then fills and
// full rises. Reset clears the running sum, level and max, sets min to 63 and empties
// both queues.
module averaging_voltmeter_min_max_display import avmm_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_in_item,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_out_item
);

    logic     wr_en;
    t_cmd_req wr_req;
    logic     rd_en;
    t_cmd_req rd_req;
    logic     q_empty;
    logic     q_full;

    assign full = q_full;

    avmm_front u_front (
        .i_item   (i_in_item),
        .i_push   (push),
        .i_q_full (q_full),
        .o_wr_en  (wr_en),
        .o_wr_req (wr_req)
    );

    avmm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (wr_req),
        .i_rd_en   (rd_en),
        .o_rd_data (rd_req),
        .o_empty   (q_empty),
        .o_full    (q_full)
    );

    avmm_back #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (rd_req),
        .i_cmd_empty (q_empty),
        .o_cmd_rd    (rd_en),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_out_item)
    );

endmodule

### design/avmm_front.sv
// Front end: accepts items, classifies them and scales converter samples.
module avmm_front import avmm_pkg::*; (
    input  t_in_item i_item,
    input  logic     i_push,
    input  logic     i_q_full,
    output logic     o_wr_en,
    output t_cmd_req o_wr_req
);

    logic [15:0] numer;
    logic [32:0] prod;
    logic        is_max;
    logic        is_min;
    logic        keep;

    assign numer = ({6'd0, i_item.sample} << 5) + {6'd0, i_item.sample}
                 + 16'(SCALE_RND);
    assign prod  = 33'(numer) * 33'(SCALE_RECIP);

    assign is_max = (i_item.opcode == OP_RX) && (i_item.rx_char == ASCII_UPPER_M);
    assign is_min = (i_item.opcode == OP_RX) && (i_item.rx_char == ASCII_LOWER_M);

    always_comb begin
        keep            = 1'b0;
        o_wr_req.code   = CMD_SAMPLE;
        o_wr_req.scaled = prod[SCALE_SHIFT +: LEVEL_W];
        case (i_item.opcode)
            OP_SAMPLE: begin
                keep = 1'b1;
            end
            OP_TICK: begin
                keep          = 1'b1;
                o_wr_req.code = CMD_TICK;
            end
            OP_RX: begin
                keep          = is_max || is_min;
                o_wr_req.code = is_max ? CMD_MAX : CMD_MIN;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_wr_en = i_push && !i_q_full && keep;

endmodule

### design/avmm_queue.sv
// Short command queue between front and back end.
module avmm_queue import avmm_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr_en,
    input  t_cmd_req i_wr_data,
    input  logic     i_rd_en,
    output t_cmd_req o_rd_data,
    output logic     o_empty,
    output logic     o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd_req           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_rd_data = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr_en) r_wr_ptr <= n_wr_ptr;
            if (i_rd_en) r_rd_ptr <= n_rd_ptr;
            if (i_wr_en && !i_rd_en)      r_count <= r_count + 1'b1;
            else if (!i_wr_en && i_rd_en) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[r_wr_ptr] <= i_wr_data;
    end

endmodule

### design/avmm_back.sv
// Back end: averaging, min/max tracking, display digits and serial report.
module avmm_back import avmm_pkg::*; #(
    parameter int SAMPLES_PER_AVERAGE = SAMPLES_PER_AVERAGE_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_req  i_cmd,
    input  logic      i_cmd_empty,
    output logic      o_cmd_rd,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_item
);

    localparam int CNT_W     = $clog2(SAMPLES_PER_AVERAGE);
    localparam int SUM_W     = $clog2(33 * SAMPLES_PER_AVERAGE + 1);
    localparam int AVG_SHIFT = SUM_W + $clog2(SAMPLES_PER_AVERAGE);
    localparam int AVG_MUL   = (2**AVG_SHIFT + SAMPLES_PER_AVERAGE - 1)
                               / SAMPLES_PER_AVERAGE;
    localparam int PROD_W    = 2 * SUM_W + 7;

    logic [CNT_W-1:0]   r_count;
    logic [SUM_W-1:0]   r_sum;
    logic [SUM_W-1:0]   r_avg_sum;
    logic               r_avg_pend;
    logic [LEVEL_W-1:0] r_level;
    logic [LEVEL_W-1:0] r_max;
    logic [LEVEL_W-1:0] r_min;
    logic               r_phase;
    logic               r_rep_active;
    logic               r_rep_max;
    logic [3:0]         r_rep_idx;
    logic [LEVEL_W-1:0] r_rep_val;
    logic               r_out_valid;
    t_out_item          r_out;

    logic [SUM_W-1:0]   sum_total;
    logic               wrap;
    logic [PROD_W-1:0]  avg_prod;
    logic [LEVEL_W-1:0] avg_level;
    logic               out_free;
    logic               take_sample;
    logic               take_other;
    logic               emit_tick;
    logic               emit_rep;
    logic [3:0]         disp_digit;
    logic [7:0]         rep_byte;
    t_out_item          n_out;

    assign sum_total = r_sum + SUM_W'(i_cmd.scaled);
    assign wrap      = (r_count == CNT_W'(SAMPLES_PER_AVERAGE - 1));
    assign avg_prod  = PROD_W'(r_avg_sum) * PROD_W'(AVG_MUL);
    assign avg_level = avg_prod[AVG_SHIFT +: LEVEL_W];

    assign out_free    = !r_out_valid || i_pop;
    assign take_sample = !i_cmd_empty && (i_cmd.code == CMD_SAMPLE);
    assign take_other  = !i_cmd_empty && (i_cmd.code != CMD_SAMPLE)
                       && !r_avg_pend && !r_rep_active && out_free;
    assign emit_tick   = take_other && (i_cmd.code == CMD_TICK);
    assign emit_rep    = r_rep_active && out_free;
    assign o_cmd_rd    = take_sample || take_other;

    assign disp_digit = r_phase ? dec_tens(r_level) : dec_units(r_level);

    always_comb begin
        case (r_rep_idx)
            4'd0:    rep_byte = ASCII_V;
            4'd1:    rep_byte = ASCII_UPPER_M;
            4'd2:    rep_byte = r_rep_max ? ASCII_A : ASCII_I;
            4'd3:    rep_byte = r_rep_max ? ASCII_X : ASCII_N;
            4'd4:    rep_byte = ASCII_EQ;
            4'd5:    rep_byte = ASCII_ZERO + {4'd0, dec_tens(r_rep_val)};
            4'd6:    rep_byte = ASCII_DOT;
            4'd7:    rep_byte = ASCII_ZERO + {4'd0, dec_units(r_rep_val)};
            4'd8:    rep_byte = ASCII_V;
            default: rep_byte = ASCII_NL;
        endcase
    end

    always_comb begin
        n_out = '0;
        if (emit_rep) begin
            n_out.kind    = KIND_SERIAL;
            n_out.tx_byte = rep_byte;
            n_out.last    = (r_rep_idx == REP_LAST_IDX);
        end else begin
            n_out.kind         = KIND_DISPLAY;
            n_out.segments     = seg_code(disp_digit);
            n_out.digit_select = r_phase;
            n_out.last         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_sum        <= '0;
            r_avg_pend   <= 1'b0;
            r_level      <= '0;
            r_max        <= '0;
            r_min        <= '1;
            r_phase      <= 1'b0;
            r_rep_active <= 1'b0;
            r_rep_idx    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_avg_pend <= take_sample && wrap;
            if (take_sample) begin
                if (wrap) begin
                    r_count <= '0;
                    r_sum   <= '0;
                end else begin
                    r_count <= r_count + 1'b1;
                    r_sum   <= sum_total;
                end
            end
            if (r_avg_pend) begin
                r_level <= avg_level;
                if (avg_level > r_max) r_max <= avg_level;
                if (avg_level < r_min) r_min <= avg_level;
            end
            if (emit_tick) r_phase <= !r_phase;
            if (take_other && (i_cmd.code == CMD_MAX || i_cmd.code == CMD_MIN)) begin
                r_rep_active <= 1'b1;
                r_rep_idx    <= '0;
            end else if (emit_rep) begin
                r_rep_idx    <= r_rep_idx + 1'b1;
                r_rep_active <= (r_rep_idx != REP_LAST_IDX);
            end
            if (emit_tick || emit_rep) r_out_valid <= 1'b1;
            else if (i_pop)            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_sample && wrap) r_avg_sum <= sum_total;
        if (take_other) begin
            r_rep_max <= (i_cmd.code == CMD_MAX);
            r_rep_val <= (i_cmd.code == CMD_MAX) ? r_max : r_min;
        end
        if (emit_tick || emit_rep) r_out <= n_out;
    end

    assign o_empty = !r_out_valid;
    assign o_item  = r_out;

endmodule
